// ===== sv/lpac_pkg.sv =====
// Package with the shared types and constants of the level pump and alarm control unit.
package lpac_pkg;

    localparam int LevelW   = 15;
    localparam int DelayW   = 13;
    localparam int SampleW  = 16;
    localparam int CountW   = 16;
    localparam int AddrW    = 5;
    localparam int DataW    = 32;
    localparam int IndexW   = 3;

    localparam logic [LevelW-1:0] SensorRangeReset = 15'h7FFF;
    localparam logic [CountW-1:0] CountMax         = 16'hFFFF;

    typedef enum logic [IndexW-1:0] {
        REG_SENSOR_RANGE = 3'd0,
        REG_START_LEVEL  = 3'd1,
        REG_STOP_LEVEL   = 3'd2,
        REG_LOW_LIMIT    = 3'd3,
        REG_HIGH_LIMIT   = 3'd4,
        REG_ALARM_DELAY  = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic pump_demand;
        logic low_alarm;
        logic high_alarm;
        logic alarm_relay;
    } result_t;

endpackage

// ===== sv/level_pump_alarm_control_unit.sv =====
// Top level of the single-channel level pump and alarm control unit.
// A result goes to the output register, or to the skid entry while that register is full and not read.
// Throughput: one sample per cycle while s_ready is high; the state update and result are one compare stage.
// A two-entry output buffer keeps s_ready high while a single result waits for m_ready.
// Synchronous active-low reset clears the flags, countdowns and output valid bits,
// and returns the configuration registers to their reset values.
module level_pump_alarm_control_unit #(
    parameter int TICKS_PER_SECOND = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpac_pkg::AddrW-1:0]        paddr,
    input  logic [lpac_pkg::DataW-1:0]        pwdata,
    output logic [lpac_pkg::DataW-1:0]        prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [lpac_pkg::SampleW-1:0] s_level_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_pump_demand,
    output logic                              m_low_alarm,
    output logic                              m_high_alarm,
    output logic                              m_alarm_relay
);

    localparam int TickW  = $clog2(TICKS_PER_SECOND + 1);
    localparam int ProdRaw = lpac_pkg::DelayW + TickW;
    localparam int ProdW  = (ProdRaw > lpac_pkg::CountW) ? ProdRaw : lpac_pkg::CountW + 1;

    logic [lpac_pkg::LevelW-1:0] sensor_range_reg;
    logic [lpac_pkg::LevelW-1:0] start_level_reg;
    logic [lpac_pkg::LevelW-1:0] stop_level_reg;
    logic [lpac_pkg::LevelW-1:0] low_limit_reg;
    logic [lpac_pkg::LevelW-1:0] high_limit_reg;
    logic [lpac_pkg::DelayW-1:0] alarm_delay_reg;

    logic                        demand_flag_reg, demand_flag_next;
    logic                        low_flag_reg, low_flag_next;
    logic                        high_flag_reg, high_flag_next;
    logic [lpac_pkg::CountW-1:0] low_count_reg, low_count_next;
    logic [lpac_pkg::CountW-1:0] high_count_reg, high_count_next;

    logic                        out_valid_reg;
    lpac_pkg::result_t           out_data_reg;
    logic                        skid_valid_reg;
    lpac_pkg::result_t           skid_data_reg;

    logic                        cfg_write;
    lpac_pkg::reg_index_t        cfg_index;
    logic                        push;
    logic                        pop;
    logic                        sample_valid;
    logic [lpac_pkg::LevelW-1:0] level;
    logic [ProdW-1:0]            reload_prod;
    logic [lpac_pkg::CountW-1:0] reload;
    lpac_pkg::result_t           result_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = lpac_pkg::reg_index_t'(paddr[lpac_pkg::AddrW-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensor_range_reg <= lpac_pkg::SensorRangeReset;
            start_level_reg  <= '0;
            stop_level_reg   <= '0;
            low_limit_reg    <= '0;
            high_limit_reg   <= '0;
            alarm_delay_reg  <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                lpac_pkg::REG_SENSOR_RANGE: sensor_range_reg <= pwdata[lpac_pkg::LevelW-1:0];
                lpac_pkg::REG_START_LEVEL:  start_level_reg  <= pwdata[lpac_pkg::LevelW-1:0];
                lpac_pkg::REG_STOP_LEVEL:   stop_level_reg   <= pwdata[lpac_pkg::LevelW-1:0];
                lpac_pkg::REG_LOW_LIMIT:    low_limit_reg    <= pwdata[lpac_pkg::LevelW-1:0];
                lpac_pkg::REG_HIGH_LIMIT:   high_limit_reg   <= pwdata[lpac_pkg::LevelW-1:0];
                lpac_pkg::REG_ALARM_DELAY:  alarm_delay_reg  <= pwdata[lpac_pkg::DelayW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            lpac_pkg::REG_SENSOR_RANGE: prdata = lpac_pkg::DataW'(sensor_range_reg);
            lpac_pkg::REG_START_LEVEL:  prdata = lpac_pkg::DataW'(start_level_reg);
            lpac_pkg::REG_STOP_LEVEL:   prdata = lpac_pkg::DataW'(stop_level_reg);
            lpac_pkg::REG_LOW_LIMIT:    prdata = lpac_pkg::DataW'(low_limit_reg);
            lpac_pkg::REG_HIGH_LIMIT:   prdata = lpac_pkg::DataW'(high_limit_reg);
            lpac_pkg::REG_ALARM_DELAY:  prdata = lpac_pkg::DataW'(alarm_delay_reg);
            default:                    prdata = '0;
        endcase
    end

    // The reload value saturates at the full countdown range.
    assign reload_prod = ProdW'(alarm_delay_reg) * ProdW'(TICKS_PER_SECOND);
    assign reload      = (reload_prod > ProdW'(lpac_pkg::CountMax)) ? lpac_pkg::CountMax
                                                                    : reload_prod[lpac_pkg::CountW-1:0];

    assign level        = s_level_sample[lpac_pkg::LevelW-1:0];
    assign sample_valid = !s_level_sample[lpac_pkg::SampleW-1] && (level != '0)
                          && (level <= sensor_range_reg);

    always_comb begin
        demand_flag_next = demand_flag_reg;
        if (!sample_valid || (start_level_reg >= stop_level_reg)) begin
            demand_flag_next = 1'b0;
        end else if (start_level_reg > level) begin
            demand_flag_next = 1'b1;
        end else if (stop_level_reg < level) begin
            demand_flag_next = 1'b0;
        end
    end

    always_comb begin
        low_flag_next   = low_flag_reg;
        high_flag_next  = high_flag_reg;
        low_count_next  = low_count_reg;
        high_count_next = high_count_reg;
        if (!sample_valid) begin
            low_flag_next   = 1'b0;
            high_flag_next  = 1'b0;
            low_count_next  = reload;
            high_count_next = reload;
        end else if (low_limit_reg > level) begin
            if (low_count_reg != '0) begin
                low_count_next = low_count_reg - lpac_pkg::CountW'(1);
            end else begin
                low_flag_next  = 1'b1;
                high_flag_next = 1'b0;
            end
        end else if ((high_limit_reg != '0) && (high_limit_reg < level)) begin
            if (high_count_reg != '0) begin
                high_count_next = high_count_reg - lpac_pkg::CountW'(1);
            end else begin
                low_flag_next  = 1'b0;
                high_flag_next = 1'b1;
            end
        end else begin
            // In the neutral band both countdowns reload; low releases above start, high below stop.
            low_count_next  = reload;
            high_count_next = reload;
            if ((low_flag_reg && (start_level_reg < level))
                || (high_flag_reg && (stop_level_reg > level))) begin
                low_flag_next  = 1'b0;
                high_flag_next = 1'b0;
            end
        end
    end

    assign result_next.pump_demand = demand_flag_next;
    assign result_next.low_alarm   = low_flag_next;
    assign result_next.high_alarm  = high_flag_next;
    assign result_next.alarm_relay = low_flag_next || high_flag_next;

    assign s_ready = !skid_valid_reg;
    assign push    = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            demand_flag_reg <= 1'b0;
            low_flag_reg    <= 1'b0;
            high_flag_reg   <= 1'b0;
            low_count_reg   <= '0;
            high_count_reg  <= '0;
        end else if (push) begin
            demand_flag_reg <= demand_flag_next;
            low_flag_reg    <= low_flag_next;
            high_flag_reg   <= high_flag_next;
            low_count_reg   <= low_count_next;
            high_count_reg  <= high_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (push) begin
                out_data_reg <= result_next;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_data_reg <= result_next;
            end else begin
                skid_data_reg <= result_next;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_pump_demand = out_data_reg.pump_demand;
    assign m_low_alarm   = out_data_reg.low_alarm;
    assign m_high_alarm  = out_data_reg.high_alarm;
    assign m_alarm_relay = out_data_reg.alarm_relay;

    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry held without a result in the output register.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(low_flag_reg && high_flag_reg))
        else $error("Low and high alarms latched together.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !sample_valid) |=> (!low_flag_reg && !high_flag_reg && !demand_flag_reg
                                     && (low_count_reg == high_count_reg)))
        else $error("Invalid sample did not clear the alarms and demand.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("Skid entry filled while the output was free.");

endmodule

// ===== tb/tb_level_pump_alarm_control_unit.sv =====
// Self-checking testbench for the level pump and alarm control unit with a built-in predictor.
`timescale 1ns / 1ps

module tb_level_pump_alarm_control_unit;

    localparam int TicksPerSecond = 10;
    localparam int ResetCycles    = 5;
    localparam int HoldCycles     = 80;
    localparam int DrainCycles    = 10;
    localparam logic [lpac_pkg::AddrW-1:0] UnusedRegAddr = 5'd24;

    logic                                aclk           = 1'b0;
    logic                                aresetn        = 1'b0;
    logic                                psel           = 1'b0;
    logic                                penable        = 1'b0;
    logic                                pwrite         = 1'b0;
    logic [lpac_pkg::AddrW-1:0]          paddr          = '0;
    logic [lpac_pkg::DataW-1:0]          pwdata         = '0;
    logic [lpac_pkg::DataW-1:0]          prdata;
    logic                                pready;
    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic signed [lpac_pkg::SampleW-1:0] s_level_sample = '0;
    logic                                m_valid;
    logic                                m_ready        = 1'b0;
    logic                                m_pump_demand;
    logic                                m_low_alarm;
    logic                                m_high_alarm;
    logic                                m_alarm_relay;

    level_pump_alarm_control_unit #(
        .TICKS_PER_SECOND(TicksPerSecond)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_level_sample (s_level_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pump_demand  (m_pump_demand),
        .m_low_alarm    (m_low_alarm),
        .m_high_alarm   (m_high_alarm),
        .m_alarm_relay  (m_alarm_relay)
    );

    always #5 aclk = ~aclk;

    // Predictor copy of the configuration and the control state.
    logic [lpac_pkg::LevelW-1:0] cfg_sensor_range = lpac_pkg::SensorRangeReset;
    logic [lpac_pkg::LevelW-1:0] cfg_start_level  = '0;
    logic [lpac_pkg::LevelW-1:0] cfg_stop_level   = '0;
    logic [lpac_pkg::LevelW-1:0] cfg_low_limit    = '0;
    logic [lpac_pkg::LevelW-1:0] cfg_high_limit   = '0;
    logic [lpac_pkg::DelayW-1:0] cfg_alarm_delay  = '0;
    logic                        demand_on        = 1'b0;
    logic                        low_latched      = 1'b0;
    logic                        high_latched     = 1'b0;
    logic [lpac_pkg::CountW-1:0] low_count        = '0;
    logic [lpac_pkg::CountW-1:0] high_count       = '0;

    logic signed [lpac_pkg::SampleW-1:0] level_pending_q[$];
    lpac_pkg::result_t                   level_expect_q[$];

    int samples_queued     = 0;
    int samples_accepted   = 0;
    int results_checked    = 0;
    int error_count        = 0;
    int settings_applied   = 0;
    int low_latches        = 0;
    int high_latches       = 0;
    int input_stall_cycles = 0;
    int burst_left         = 0;
    int gap_left           = 0;
    int hold_left          = 0;
    int holds_done         = 0;
    int unsigned rx_cycle  = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch: %s, got %0d expected %0d (result %0d, t=%0t)",
                 what, got, want, results_checked, $realtime);
    endtask

    function automatic lpac_pkg::result_t predict_levels(
        input logic signed [lpac_pkg::SampleW-1:0] sample);
        int                s;
        int                reload;
        logic              in_range;
        logic              was_low;
        logic              was_high;
        lpac_pkg::result_t res;
        s        = sample;
        in_range = (s > 0) && (s <= int'(cfg_sensor_range));
        reload   = int'(cfg_alarm_delay) * TicksPerSecond;
        if (reload > int'(lpac_pkg::CountMax))
            reload = int'(lpac_pkg::CountMax);
        was_low  = low_latched;
        was_high = high_latched;

        if (!in_range)
            demand_on = 1'b0;
        else if (cfg_start_level >= cfg_stop_level)
            demand_on = 1'b0;
        else if (int'(cfg_start_level) > s)
            demand_on = 1'b1;
        else if (int'(cfg_stop_level) < s)
            demand_on = 1'b0;

        if (!in_range) begin
            low_count    = reload[lpac_pkg::CountW-1:0];
            high_count   = reload[lpac_pkg::CountW-1:0];
            low_latched  = 1'b0;
            high_latched = 1'b0;
        end else if (int'(cfg_low_limit) > s) begin
            if (low_count != 0) begin
                low_count = low_count - lpac_pkg::CountW'(1);
            end else begin
                low_latched  = 1'b1;
                high_latched = 1'b0;
            end
        end else if (cfg_high_limit != 0 && int'(cfg_high_limit) < s) begin
            if (high_count != 0) begin
                high_count = high_count - lpac_pkg::CountW'(1);
            end else begin
                low_latched  = 1'b0;
                high_latched = 1'b1;
            end
        end else if ((low_latched && int'(cfg_start_level) < s) ||
                     (high_latched && int'(cfg_stop_level) > s)) begin
            low_count    = reload[lpac_pkg::CountW-1:0];
            high_count   = reload[lpac_pkg::CountW-1:0];
            low_latched  = 1'b0;
            high_latched = 1'b0;
        end else begin
            low_count  = reload[lpac_pkg::CountW-1:0];
            high_count = reload[lpac_pkg::CountW-1:0];
        end

        if (low_latched && !was_low)
            low_latches++;
        if (high_latched && !was_high)
            high_latches++;
        res.pump_demand = demand_on;
        res.low_alarm   = low_latched;
        res.high_alarm  = high_latched;
        res.alarm_relay = low_latched | high_latched;
        return res;
    endfunction

    // Sample driver: bursts of transactions separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                level_expect_q.push_back(predict_levels(s_level_sample));
                samples_accepted++;
            end
            if (s_valid && !s_ready)
                input_stall_cycles++;
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (level_pending_q.size() != 0) begin
                    s_valid        <= 1'b1;
                    s_level_sample <= level_pending_q.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(40, 1);
                        gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_result();
        lpac_pkg::result_t got;
        lpac_pkg::result_t want;
        got = {m_pump_demand, m_low_alarm, m_high_alarm, m_alarm_relay};
        if (level_expect_q.size() == 0) begin
            report_mismatch("result transaction with no sample outstanding", 1, 0);
            return;
        end
        want = level_expect_q.pop_front();
        if (got.pump_demand !== want.pump_demand)
            report_mismatch("pump_demand", got.pump_demand, want.pump_demand);
        if (got.low_alarm !== want.low_alarm)
            report_mismatch("low_alarm", got.low_alarm, want.low_alarm);
        if (got.high_alarm !== want.high_alarm)
            report_mismatch("high_alarm", got.high_alarm, want.high_alarm);
        if (got.alarm_relay !== want.alarm_relay)
            report_mismatch("alarm_relay", got.alarm_relay, want.alarm_relay);
        results_checked++;
    endtask

    // Result monitor with its own stall pattern and two long hold-offs.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                check_result();
            rx_cycle++;
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (holds_done < 2 &&
                         results_checked >= (holds_done == 0 ? 180 : 640)) begin
                holds_done++;
                hold_left = HoldCycles;
                m_ready <= 1'b0;
            end else begin
                case ((rx_cycle >> 6) % 4)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(1, 0));
                    2:       m_ready <= (rx_cycle % 4 == 0);
                    default: m_ready <= ($urandom_range(9, 0) != 0);
                endcase
            end
        end
    end

    task automatic apb_write(input logic [lpac_pkg::AddrW-1:0] addr,
                             input logic [lpac_pkg::DataW-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg(input lpac_pkg::reg_index_t idx,
                             input logic [lpac_pkg::DataW-1:0] data);
        apb_write({idx, 2'b00}, data);
        case (idx)
            lpac_pkg::REG_SENSOR_RANGE: cfg_sensor_range = data[lpac_pkg::LevelW-1:0];
            lpac_pkg::REG_START_LEVEL:  cfg_start_level  = data[lpac_pkg::LevelW-1:0];
            lpac_pkg::REG_STOP_LEVEL:   cfg_stop_level   = data[lpac_pkg::LevelW-1:0];
            lpac_pkg::REG_LOW_LIMIT:    cfg_low_limit    = data[lpac_pkg::LevelW-1:0];
            lpac_pkg::REG_HIGH_LIMIT:   cfg_high_limit   = data[lpac_pkg::LevelW-1:0];
            lpac_pkg::REG_ALARM_DELAY:  cfg_alarm_delay  = data[lpac_pkg::DelayW-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [lpac_pkg::DataW-1:0] reg_word(input int value,
                                                            input bit junk_upper);
        logic [lpac_pkg::DataW-1:0] word;
        word = junk_upper ? lpac_pkg::DataW'($urandom) : '0;
        word[lpac_pkg::LevelW-1:0] = value[lpac_pkg::LevelW-1:0];
        return word;
    endfunction

    task automatic apply_setting(input int rng, input int start_lvl, input int stop_lvl,
                                 input int low_lvl, input int high_lvl, input int delay_s,
                                 input bit junk_upper);
        logic [lpac_pkg::DataW-1:0] delay_word;
        delay_word = junk_upper ? lpac_pkg::DataW'($urandom) : '0;
        delay_word[lpac_pkg::DelayW-1:0] = delay_s[lpac_pkg::DelayW-1:0];
        write_reg(lpac_pkg::REG_SENSOR_RANGE, reg_word(rng, junk_upper));
        write_reg(lpac_pkg::REG_START_LEVEL,  reg_word(start_lvl, junk_upper));
        write_reg(lpac_pkg::REG_STOP_LEVEL,   reg_word(stop_lvl, junk_upper));
        write_reg(lpac_pkg::REG_LOW_LIMIT,    reg_word(low_lvl, junk_upper));
        write_reg(lpac_pkg::REG_HIGH_LIMIT,   reg_word(high_lvl, junk_upper));
        write_reg(lpac_pkg::REG_ALARM_DELAY,  delay_word);
        settings_applied++;
    endtask

    task automatic queue_sample(input int value);
        level_pending_q.push_back(value[lpac_pkg::SampleW-1:0]);
        samples_queued++;
    endtask

    function automatic int pick_level(input int region);
        int top;
        int v;
        top = int'(cfg_sensor_range);
        v   = (top >= 1) ? 1 + int'($urandom_range(top - 1, 0)) : 0;
        case (region)
            0: begin
                case ($urandom_range(3, 0))
                    0: v = 0;
                    1: v = -1 - int'($urandom_range(32767, 0));
                    2: if (top < 32767) v = top + 1 + int'($urandom_range(32766 - top, 0));
                    default: v = int'($urandom_range(65535, 0));
                endcase
            end
            1, 2, 3: begin
                if (cfg_low_limit > 1)
                    v = 1 + int'($urandom_range(int'(cfg_low_limit) - 2, 0));
            end
            4, 5, 6: begin
                if (cfg_high_limit != 0 && int'(cfg_high_limit) < top)
                    v = int'(cfg_high_limit) + 1 +
                        int'($urandom_range(top - int'(cfg_high_limit) - 1, 0));
            end
            7: begin
                case ($urandom_range(4, 0))
                    0: v = int'(cfg_start_level);
                    1: v = int'(cfg_stop_level);
                    2: v = int'(cfg_low_limit);
                    3: v = int'(cfg_high_limit);
                    default: v = top;
                endcase
                v = v + int'($urandom_range(2, 0)) - 1;
            end
            default: ;
        endcase
        return v;
    endfunction

    // Random-length runs of samples in one region; long runs outlast a short countdown.
    task automatic queue_level_runs(input int count);
        int left;
        int region;
        int run_len;
        int reload;
        left   = count;
        reload = int'(cfg_alarm_delay) * TicksPerSecond;
        if (reload > 30)
            reload = 30;
        while (left > 0) begin
            region  = $urandom_range(9, 0);
            run_len = $urandom_range(reload + 6, 1);
            if (run_len > left)
                run_len = left;
            repeat (run_len) begin
                queue_sample(pick_level(region));
                left--;
            end
        end
    endtask

    task automatic wait_drained();
        while (samples_accepted != samples_queued || level_expect_q.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    initial begin
        int rng;
        int boundary_levels[6];
        int fixed_levels[16];
        boundary_levels = '{0, 1, -1, -32768, 32767, 21845};
        fixed_levels    = '{50, 150, 400, 950, 800, 500, 1000, 1001,
                            50, 950, 0, 100, 900, 700, 300, -32768};
        repeat (ResetCycles) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (boundary_levels[i])
            queue_sample(boundary_levels[i]);
        wait_drained();

        apply_setting(1000, 300, 700, 100, 900, 0, 1'b0);
        apb_write(UnusedRegAddr, 32'h0000_1234);
        foreach (fixed_levels[i])
            queue_sample(fixed_levels[i]);
        wait_drained();

        apply_setting(1000, 300, 700, 100, 900, 1, 1'b0);
        queue_level_runs(100);
        wait_drained();
        apply_setting(32767, 0, 32767, 32767, 32767, 0, 1'b0);
        queue_level_runs(80);
        wait_drained();
        apply_setting(0, 32767, 0, 0, 0, 8191, 1'b1);
        queue_level_runs(40);
        wait_drained();
        apply_setting(5000, 600, 400, 500, 200, 2, 1'b0);
        queue_level_runs(100);
        wait_drained();
        apply_setting(5000, 1000, 4000, 800, 4500, 0, 1'b1);
        queue_level_runs(100);
        wait_drained();
        apply_setting(32767, 100, 32000, 50, 32700, 6553, 1'b0);
        queue_level_runs(40);
        wait_drained();

        repeat (5) begin
            rng = $urandom_range(32767, 100);
            apply_setting(rng, $urandom_range(rng, 0), $urandom_range(rng, 0),
                          $urandom_range(rng, 0),
                          ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(rng, 0),
                          $urandom_range(3, 0), 1'b0);
            queue_level_runs(90);
            wait_drained();
        end

        repeat (DrainCycles) @(posedge aclk);
        if (level_expect_q.size() != 0)
            report_mismatch("results still outstanding at the end", 0,
                            level_expect_q.size());
        $display("Checked %0d level samples under %0d register settings, %0d low and %0d high",
                 results_checked, settings_applied, low_latches, high_latches);
        $display("alarm latches; the sample input was stalled for %0d cycles by back-pressure.",
                 input_stall_cycles);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run timed out with %0d of %0d samples accepted.",
                 samples_accepted, samples_queued);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
